[src/blehid_pkg.sv]
// Shared types and constants for the BLE advertisement HID filter.
package blehid_pkg;

  localparam logic [15:0] HID_UUID_DEFAULT      = 16'h1812;
  localparam logic [15:0] KBD_APPEAR_DEFAULT    = 16'd961;
  localparam logic [7:0]  UUID_PART_TYPE_DEFAULT = 8'd2;
  localparam logic [7:0]  UUID_COMP_TYPE_DEFAULT = 8'd3;
  localparam logic [7:0]  APPEAR_TYPE_DEFAULT   = 8'd25;

  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W  = 16;

  localparam logic [REG_INDEX_W-1:0] REG_SERVICE_UUID  = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_KBD_APPEAR    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_UUID_PARTIAL  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_UUID_COMPLETE = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_APPEAR_TYPE   = 3'd4;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_TYPE,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic [15:0] service_uuid;
    logic [15:0] keyboard_appearance;
    logic [7:0]  uuid_partial_type;
    logic [7:0]  uuid_complete_type;
    logic [7:0]  appearance_type;
  } cfg_t;

  typedef struct packed {
    logic        hid_found;
    logic [15:0] appearance;
    logic        is_keyboard;
    logic        accept;
    logic        truncated;
  } result_t;

endpackage

[src/blehid_in_stage.sv]
// Input register stage: holds one byte item until the parser takes it.
module blehid_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       slot_free,
  output logic       take,
  output logic [7:0] byte_q,
  output logic       last_q
);

  logic valid_q;

  // A non-final byte never waits; the final byte waits for the result slot.
  assign take     = valid_q && (!last_q || slot_free);
  assign in_stall = valid_q && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

endmodule

[src/blehid_parser.sv]
// Length-type-value walker: one byte per cycle when take is high, result on the final byte.
module blehid_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  blehid_pkg::cfg_t     cfg,
  input  logic                 take,
  input  logic [7:0]           byte_q,
  input  logic                 last_q,
  output logic                 res_valid,
  output blehid_pkg::result_t  res
);
  import blehid_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        kind_uuid, kind_uuid_next;
  logic        kind_app, kind_app_next;
  logic [1:0]  pos_cnt, pos_cnt_next;     // saturates at 2
  logic        pos_odd, pos_odd_next;
  logic [7:0]  low_hold, low_hold_next;
  logic        match_pend, match_pend_next;
  logic [15:0] field_app, field_app_next;
  logic        hid_seen, hid_seen_next;
  logic        app_seen, app_seen_next;
  logic [15:0] app_val, app_val_next;

  // values after this byte, before the end-of-advertisement clear
  phase_t      ph_n;
  logic        hid_n;
  logic        aseen_n;
  logic [15:0] aval_n;

  always_comb begin
    logic [7:0] left_dec;
    logic       fin;
    logic       ku;
    logic       ka;
    logic       mp;
    logic [15:0] fa;

    left_dec = 8'(bytes_left - 8'd1);
    fin      = 1'b0;
    ku       = kind_uuid;
    ka       = kind_app;
    mp       = match_pend;
    fa       = field_app;

    phase_next      = phase;
    bytes_left_next = bytes_left;
    kind_uuid_next  = kind_uuid;
    kind_app_next   = kind_app;
    pos_cnt_next    = pos_cnt;
    pos_odd_next    = pos_odd;
    low_hold_next   = low_hold;
    match_pend_next = match_pend;
    field_app_next  = field_app;
    hid_seen_next   = hid_seen;
    app_seen_next   = app_seen;
    app_val_next    = app_val;

    if (take) begin
      unique case (phase)
        PH_LENGTH: begin
          if (byte_q == 8'd0) begin
            phase_next = PH_STOPPED;
          end else begin
            bytes_left_next = byte_q;
            phase_next      = PH_TYPE;
          end
        end
        PH_TYPE: begin
          ku = (byte_q == cfg.uuid_partial_type) || (byte_q == cfg.uuid_complete_type);
          ka = (byte_q == cfg.appearance_type) && (bytes_left >= 8'd3);
          kind_uuid_next  = ku;
          kind_app_next   = ka;
          bytes_left_next = left_dec;
          pos_cnt_next    = 2'd0;
          pos_odd_next    = 1'b0;
          if (left_dec == 8'd0) begin
            fin = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (kind_uuid) begin
            if (!pos_odd) begin
              low_hold_next = byte_q;
            end else if ({byte_q, low_hold} == cfg.service_uuid) begin
              mp = 1'b1;
            end
          end
          if (kind_app) begin
            if (pos_cnt == 2'd0) begin
              fa = {8'd0, byte_q};
            end else if (pos_cnt == 2'd1) begin
              fa = {byte_q, field_app[7:0]};
            end
          end
          match_pend_next = mp;
          field_app_next  = fa;
          pos_odd_next    = !pos_odd;
          pos_cnt_next    = (pos_cnt == 2'd2) ? pos_cnt : 2'(pos_cnt + 2'd1);
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            fin = 1'b1;
          end
        end
        PH_STOPPED: begin
        end
        default: begin
        end
      endcase

      if (fin) begin
        if (mp) begin
          hid_seen_next = 1'b1;
        end
        if (ka && !app_seen) begin
          app_seen_next = 1'b1;
          app_val_next  = fa;
        end
        phase_next      = PH_LENGTH;
        bytes_left_next = 8'd0;
        kind_uuid_next  = 1'b0;
        kind_app_next   = 1'b0;
        pos_cnt_next    = 2'd0;
        pos_odd_next    = 1'b0;
        low_hold_next   = 8'd0;
        match_pend_next = 1'b0;
        field_app_next  = 16'd0;
      end
    end

    ph_n    = phase_next;
    hid_n   = hid_seen_next;
    aseen_n = app_seen_next;
    aval_n  = app_val_next;

    // final byte: all parse state goes back to reset; the *_n values above keep the result
    if (take && last_q) begin
      phase_next      = PH_LENGTH;
      bytes_left_next = 8'd0;
      kind_uuid_next  = 1'b0;
      kind_app_next   = 1'b0;
      pos_cnt_next    = 2'd0;
      pos_odd_next    = 1'b0;
      low_hold_next   = 8'd0;
      match_pend_next = 1'b0;
      field_app_next  = 16'd0;
      hid_seen_next   = 1'b0;
      app_seen_next   = 1'b0;
      app_val_next    = 16'd0;
    end
  end

  always_comb begin
    logic [15:0] app;
    logic        kb;
    app             = aseen_n ? aval_n : 16'd0;
    kb              = (app == cfg.keyboard_appearance);
    res_valid       = take && last_q;
    res.hid_found   = hid_n;
    res.appearance  = app;
    res.is_keyboard = kb;
    res.accept      = hid_n || kb;
    res.truncated   = (ph_n == PH_TYPE) || (ph_n == PH_PAYLOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LENGTH;
      bytes_left <= 8'd0;
      kind_uuid  <= 1'b0;
      kind_app   <= 1'b0;
      pos_cnt    <= 2'd0;
      pos_odd    <= 1'b0;
      low_hold   <= 8'd0;
      match_pend <= 1'b0;
      field_app  <= 16'd0;
      hid_seen   <= 1'b0;
      app_seen   <= 1'b0;
      app_val    <= 16'd0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      kind_uuid  <= kind_uuid_next;
      kind_app   <= kind_app_next;
      pos_cnt    <= pos_cnt_next;
      pos_odd    <= pos_odd_next;
      low_hold   <= low_hold_next;
      match_pend <= match_pend_next;
      field_app  <= field_app_next;
      hid_seen   <= hid_seen_next;
      app_seen   <= app_seen_next;
      app_val    <= app_val_next;
    end
  end

`ifndef SYNTH
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (phase == PH_LENGTH) && !hid_seen && !app_seen && !match_pend)
    else $error("parse state not cleared after result");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != 8'd0))
    else $error("payload phase with no bytes left");

  a_appearance_gated: assert property (@(posedge clk) disable iff (rst)
    !app_seen |-> (app_val == 16'd0))
    else $error("appearance value set without appearance seen");
`endif

endmodule

[src/blehid_out_stage.sv]
// Result register: holds one result item until the receiver takes it.
module blehid_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  blehid_pkg::result_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output blehid_pkg::result_t res_q,
  output logic                slot_free
);

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      res_q <= res;
    end
  end

endmodule

[src/ble_adv_hid_filter_top.sv]
// BLE advertisement HID filter: top level with configuration registers.
//
// Input channel (in_valid / in_stall): one advertisement byte per item,
// advertising data then scan response, last_byte high on the final byte.
// Output channel (out_valid / out_stall): one result item per advertisement,
// showing whether a UUID list held service_uuid, the first appearance
// value, whether it is a keyboard, the accept decision and a truncation flag.
// Throughput: one byte per cycle; an input register feeds a combinational
// parse step whose result lands in an output register.
// The result is written into the output register when the parser takes the final byte.
// Only the final byte can be held back: while the result register is full
// and stalled it waits in the input register, and in_stall rises.
// Non-final bytes keep flowing while a result waits.
// Configuration: wr_en writes wr_data to register wr_index (0 service UUID,
// 1 keyboard appearance, 2/3 partial/complete UUID list type, 4 appearance
// type); other indexes are ignored. Write only while the block is idle.
// Reset (rst, synchronous) clears all parse state and the channel valids and
// loads the register defaults (HID service UUID, keyboard appearance).
module ble_adv_hid_filter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hid_found,
  output logic [15:0]                        appearance,
  output logic                               is_keyboard,
  output logic                               accept,
  output logic                               truncated,
  input  logic                               wr_en,
  input  logic [blehid_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [blehid_pkg::REG_DATA_W-1:0]  wr_data
);
  import blehid_pkg::*;

  cfg_t       cfg;
  logic       slot_free;
  logic       take;
  logic [7:0] byte_q;
  logic       last_q;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.service_uuid        <= HID_UUID_DEFAULT;
      cfg.keyboard_appearance <= KBD_APPEAR_DEFAULT;
      cfg.uuid_partial_type   <= UUID_PART_TYPE_DEFAULT;
      cfg.uuid_complete_type  <= UUID_COMP_TYPE_DEFAULT;
      cfg.appearance_type     <= APPEAR_TYPE_DEFAULT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SERVICE_UUID:  cfg.service_uuid        <= wr_data;
        REG_KBD_APPEAR:    cfg.keyboard_appearance <= wr_data;
        REG_UUID_PARTIAL:  cfg.uuid_partial_type   <= wr_data[7:0];
        REG_UUID_COMPLETE: cfg.uuid_complete_type  <= wr_data[7:0];
        REG_APPEAR_TYPE:   cfg.appearance_type     <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  blehid_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .slot_free (slot_free),
    .take      (take),
    .byte_q    (byte_q),
    .last_q    (last_q)
  );

  blehid_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .byte_q    (byte_q),
    .last_q    (last_q),
    .res_valid (res_valid),
    .res       (res)
  );

  blehid_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .slot_free (slot_free)
  );

  assign hid_found   = res_q.hid_found;
  assign appearance  = res_q.appearance;
  assign is_keyboard = res_q.is_keyboard;
  assign accept      = res_q.accept;
  assign truncated   = res_q.truncated;

endmodule
